/* design/pss_pkg.sv */
`timescale 1ns / 1ps

package pss_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;
    localparam logic [31:0] HALF_SEC_NS = 32'd500000000;

    localparam logic [3:0] CMD_SYNC       = 4'h0;
    localparam logic [3:0] CMD_FOLLOW_UP  = 4'h8;
    localparam logic [3:0] CMD_DELAY_RESP = 4'h9;
    localparam logic [3:0] CMD_IGNORE_A   = 4'h3;
    localparam logic [3:0] CMD_IGNORE_B   = 4'hA;
    localparam logic [3:0] CMD_IGNORE_C   = 4'hB;

    typedef enum logic [1:0] {
        JOB_NONE,
        JOB_REQUEST,
        JOB_REPORT,
        JOB_ERROR
    } job_kind_t;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [47:0] local_sec;
        logic [29:0] local_ns;
        logic [47:0] msg_sec;
        logic [29:0] msg_ns;
    } item_t;

    typedef struct packed {
        logic               status;
        logic               send_request;
        logic [47:0]        request_sec;
        logic [29:0]        request_ns;
        logic               report_valid;
        logic signed [63:0] synced_sec;
        logic signed [31:0] synced_ns;
        logic signed [63:0] diff_sec;
        logic signed [31:0] diff_ns;
    } result_t;

    // t1..t4 and local time snapshot handed from front to back
    typedef struct packed {
        job_kind_t   kind;
        logic [47:0] t1_sec;
        logic [29:0] t1_ns;
        logic [47:0] t2_sec;
        logic [29:0] t2_ns;
        logic [47:0] t3_sec;
        logic [29:0] t3_ns;
        logic [47:0] t4_sec;
        logic [29:0] t4_ns;
        logic [47:0] loc_sec;
        logic [29:0] loc_ns;
    } job_t;

    function automatic logic [63:0] ext_sec(input logic [47:0] s);
        return {16'b0, s};
    endfunction

    function automatic logic [31:0] ext_ns(input logic [29:0] n);
        return {2'b0, n};
    endfunction

    // signed halving, truncating toward zero; odd seconds add half a second
    function automatic logic [31:0] half_ns(input logic [31:0] n, input logic odd);
        logic [31:0] v;
        logic [31:0] h;
        v = n + {31'b0, n[31]};
        h = {v[31], v[31:1]};
        return odd ? h + HALF_SEC_NS : h;
    endfunction

    function automatic logic [63:0] half_sec(input logic [63:0] s);
        return {s[63], s[63:1]};
    endfunction

endpackage

/* design/pss_front.sv */
`timescale 1ns / 1ps

module pss_front (
    input  logic          clk,
    input  logic          rst_n,
    input  pss_pkg::item_t item,
    input  logic          push,
    output logic          full,
    input  logic          q_full,
    output logic          job_push,
    output pss_pkg::job_t job
);
    import pss_pkg::*;

    logic [47:0] t1_sec_reg, t1_sec_next;
    logic [29:0] t1_ns_reg, t1_ns_next;
    logic [47:0] t2_sec_reg, t2_sec_next;
    logic [29:0] t2_ns_reg, t2_ns_next;
    logic [47:0] t3_sec_reg, t3_sec_next;
    logic [29:0] t3_ns_reg, t3_ns_next;
    logic        accept;
    job_kind_t   kind;

    assign full     = q_full;
    assign accept   = push && !q_full;
    assign job_push = accept;

    always_comb
    begin
        t1_sec_next = t1_sec_reg;
        t1_ns_next  = t1_ns_reg;
        t2_sec_next = t2_sec_reg;
        t2_ns_next  = t2_ns_reg;
        t3_sec_next = t3_sec_reg;
        t3_ns_next  = t3_ns_reg;
        kind        = JOB_NONE;
        unique case (item.cmd) inside
            CMD_SYNC:
            begin
                t2_sec_next = item.local_sec;
                t2_ns_next  = item.local_ns;
            end
            CMD_FOLLOW_UP:
            begin
                kind        = JOB_REQUEST;
                t1_sec_next = item.msg_sec;
                t1_ns_next  = item.msg_ns;
                t3_sec_next = item.local_sec;
                t3_ns_next  = item.local_ns;
            end
            CMD_DELAY_RESP:
            begin
                kind = JOB_REPORT;
            end
            CMD_IGNORE_A, CMD_IGNORE_B, CMD_IGNORE_C:
            begin
                kind = JOB_NONE;
            end
            default:
            begin
                kind = JOB_ERROR;
            end
        endcase
    end

    // job carries the timestamps as they stand after this message
    always_comb
    begin
        job.kind    = kind;
        job.t1_sec  = t1_sec_next;
        job.t1_ns   = t1_ns_next;
        job.t2_sec  = t2_sec_next;
        job.t2_ns   = t2_ns_next;
        job.t3_sec  = t3_sec_next;
        job.t3_ns   = t3_ns_next;
        job.t4_sec  = item.msg_sec;
        job.t4_ns   = item.msg_ns;
        job.loc_sec = item.local_sec;
        job.loc_ns  = item.local_ns;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_sec_reg <= '0;
            t1_ns_reg  <= '0;
            t2_sec_reg <= '0;
            t2_ns_reg  <= '0;
            t3_sec_reg <= '0;
            t3_ns_reg  <= '0;
        end
        else if (accept)
        begin
            t1_sec_reg <= t1_sec_next;
            t1_ns_reg  <= t1_ns_next;
            t2_sec_reg <= t2_sec_next;
            t2_ns_reg  <= t2_ns_next;
            t3_sec_reg <= t3_sec_next;
            t3_ns_reg  <= t3_ns_next;
        end
    end

endmodule

/* design/pss_queue.sv */
`timescale 1ns / 1ps

module pss_queue #(
    parameter int DEPTH = pss_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  pss_pkg::job_t wr_data,
    output logic          q_full,
    input  logic          rd_en,
    output pss_pkg::job_t rd_data,
    output logic          q_empty
);
    import pss_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign q_full  = (count_reg == CW'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

endmodule

/* design/pss_back.sv */
`timescale 1ns / 1ps

module pss_back (
    input  logic            clk,
    input  logic            rst_n,
    input  pss_pkg::job_t   job,
    input  logic            job_valid,
    output logic            job_take,
    output pss_pkg::result_t result,
    output logic            empty,
    input  logic            pop
);
    import pss_pkg::*;

    // stage valids: 1 differences, 2 sum/difference, 3 halves, 4 prop, 5 result
    logic [5:1] v_reg, v_next;
    logic [5:1] acc;
    logic [5:1] mov;

    job_kind_t   k1_reg, k2_reg, k3_reg, k4_reg;
    logic [47:0] t3s1_reg, t3s2_reg, t3s3_reg, t3s4_reg;
    logic [29:0] t3n1_reg, t3n2_reg, t3n3_reg, t3n4_reg;
    logic [63:0] tls1_reg, tls2_reg, tls3_reg, tls4_reg;
    logic [31:0] tln1_reg, tln2_reg, tln3_reg, tln4_reg;
    logic [63:0] as1_reg, bs1_reg;
    logic [31:0] an1_reg, bn1_reg;
    logic [63:0] ps2_reg, ms2_reg;
    logic [31:0] pn2_reg, mn2_reg;
    logic [63:0] ds3_reg, os3_reg;
    logic [31:0] dn3_reg, on3_reg;
    logic [63:0] prs4_reg;
    logic [31:0] prn4_reg;
    result_t     res_reg, res_next;

    assign empty  = !v_reg[5];
    assign result = res_reg;

    always_comb
    begin
        acc[5] = !v_reg[5] || pop;
        for (int i = 4; i >= 1; i--)
            acc[i] = !v_reg[i] || (v_reg[i] && acc[i+1]);
        for (int i = 1; i <= 4; i++)
            mov[i] = v_reg[i] && acc[i+1];
        mov[5] = v_reg[5] && pop;
        v_next[1] = job_valid || (v_reg[1] && !mov[1]);
        for (int i = 2; i <= 5; i++)
            v_next[i] = mov[i-1] || (v_reg[i] && !mov[i]);
    end

    assign job_take = job_valid && acc[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next & {4'b1111, acc[1] ? 1'b1 : v_reg[1]};
    end

    always_comb
    begin
        res_next = '0;
        case (k4_reg)
            JOB_REQUEST:
            begin
                res_next.send_request = 1'b1;
                res_next.request_sec  = t3s4_reg;
                res_next.request_ns   = t3n4_reg;
            end
            JOB_REPORT:
            begin
                res_next.report_valid = 1'b1;
                res_next.synced_sec   = ext_sec(t3s4_reg) + prs4_reg;
                res_next.synced_ns    = ext_ns(t3n4_reg) + prn4_reg;
                res_next.diff_sec     = tls4_reg + prs4_reg;
                res_next.diff_ns      = tln4_reg + prn4_reg;
            end
            JOB_ERROR:
                res_next.status = 1'b1;
            default:
                res_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (job_take)
        begin
            k1_reg   <= job.kind;
            t3s1_reg <= job.t3_sec;
            t3n1_reg <= job.t3_ns;
            as1_reg  <= ext_sec(job.t2_sec) - ext_sec(job.t1_sec);
            an1_reg  <= ext_ns(job.t2_ns) - ext_ns(job.t1_ns);
            bs1_reg  <= ext_sec(job.t4_sec) - ext_sec(job.t3_sec);
            bn1_reg  <= ext_ns(job.t4_ns) - ext_ns(job.t3_ns);
            tls1_reg <= ext_sec(job.t3_sec) - ext_sec(job.loc_sec);
            tln1_reg <= ext_ns(job.t3_ns) - ext_ns(job.loc_ns);
        end
        if (mov[1])
        begin
            k2_reg   <= k1_reg;
            t3s2_reg <= t3s1_reg;
            t3n2_reg <= t3n1_reg;
            tls2_reg <= tls1_reg;
            tln2_reg <= tln1_reg;
            ps2_reg  <= as1_reg + bs1_reg;
            pn2_reg  <= an1_reg + bn1_reg;
            ms2_reg  <= as1_reg - bs1_reg;
            mn2_reg  <= an1_reg - bn1_reg;
        end
        if (mov[2])
        begin
            k3_reg   <= k2_reg;
            t3s3_reg <= t3s2_reg;
            t3n3_reg <= t3n2_reg;
            tls3_reg <= tls2_reg;
            tln3_reg <= tln2_reg;
            ds3_reg  <= half_sec(ps2_reg);
            dn3_reg  <= half_ns(pn2_reg, ps2_reg[0]);
            os3_reg  <= half_sec(ms2_reg);
            on3_reg  <= half_ns(mn2_reg, ms2_reg[0]);
        end
        if (mov[3])
        begin
            k4_reg   <= k3_reg;
            t3s4_reg <= t3s3_reg;
            t3n4_reg <= t3n3_reg;
            tls4_reg <= tls3_reg;
            tln4_reg <= tln3_reg;
            prs4_reg <= ds3_reg - os3_reg;
            prn4_reg <= dn3_reg - on3_reg;
        end
        if (mov[4])
            res_reg <= res_next;
    end

endmodule

/* design/ptp_slave_sync_timestamp_engine.sv */
`timescale 1ns / 1ps

// PTP slave timestamp engine.
// Input channel (item, push/full): one received message per beat - type
// nibble, local clock reading and the message timestamp. Sync latches t2,
// Follow_Up latches t1 and t3 and asks for a Delay_Req stamped t3,
// Delay_Resp takes t4 and reports synced time and its difference to local.
// Result channel (result, empty/pop): exactly one result beat per item,
// in order; the head result is shown while empty is low.
// Front end classifies each message and updates t1..t3 in the cycle of
// acceptance, then hands a job to a small queue (QUEUE_DEPTH entries).
// Back end is a five-stage pipeline: differences, sum/difference,
// halving, propagation term, result register.
// Throughput: one item per cycle while full stays low.
// Reset clears t1..t3 to zero, and empties queue and pipeline.
// If pop is held low the pipeline fills, then the queue, then full rises;
// nothing is dropped.
module ptp_slave_sync_timestamp_engine #(
    parameter int QUEUE_DEPTH = pss_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  pss_pkg::item_t   item,
    input  logic             push,
    output logic             full,
    output pss_pkg::result_t result,
    output logic             empty,
    input  logic             pop
);
    import pss_pkg::*;

    job_t job_in;
    job_t job_out;
    logic job_push;
    logic q_full;
    logic q_empty;
    logic job_take;

    pss_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .push     (push),
        .full     (full),
        .q_full   (q_full),
        .job_push (job_push),
        .job      (job_in)
    );

    // decouples classification from the arithmetic pipeline
    pss_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_in),
        .q_full  (q_full),
        .rd_en   (job_take),
        .rd_data (job_out),
        .q_empty (q_empty)
    );

    pss_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job_out),
        .job_valid (!q_empty),
        .job_take  (job_take),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule
